>>> rtl/hamming_nearest_descriptor_match_top_assert.svh
// Assertion macros shared by the descriptor matcher RTL.
`ifndef HAMMING_NEAREST_DESCRIPTOR_MATCH_TOP_ASSERT_SVH
`define HAMMING_NEAREST_DESCRIPTOR_MATCH_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge of aclk outside reset.
`define HNDM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge of aclk outside reset.
`define HNDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hndm_pkg.sv
// Shared constants, codes and the popcount function of the descriptor matcher.
package hndm_pkg;

    localparam int DEF_MAX_REFS = 1024;
    localparam int DESC_W       = 256;
    localparam int CHUNK_W      = 32;
    localparam int NUM_CHUNKS   = DESC_W / CHUNK_W;
    localparam int CHUNK_CNT_W  = 6;
    localparam int DIST_W       = 9;
    localparam int TAG_W        = 16;
    localparam int IDX_OUT_W    = 10;
    localparam int KIND_W       = 2;

    localparam logic [DIST_W-1:0] THR_RESET = 9'd100;

    // Stream widths: input tdata is four descriptor words and the tag,
    // output tdata is tag, index and distance, padded to whole bytes.
    localparam int S_TDATA_RAW_W = DESC_W + TAG_W;
    localparam int S_TDATA_W     = ((S_TDATA_RAW_W + 7) / 8) * 8;
    localparam int S_TUSER_W     = KIND_W + 1;
    localparam int M_TDATA_RAW_W = TAG_W + IDX_OUT_W + DIST_W;
    localparam int M_TDATA_W     = ((M_TDATA_RAW_W + 7) / 8) * 8;
    localparam int M_TUSER_W     = 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Bit count of a 32-bit word by the usual pairwise folding.
    function automatic logic [CHUNK_CNT_W-1:0] ones32(input logic [CHUNK_W-1:0] x);
        logic [CHUNK_W-1:0] v;
        logic [7:0]         s;
        v = x - ((x >> 1) & 32'h5555_5555);
        v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
        v = (v + (v >> 4)) & 32'h0F0F_0F0F;
        s = v[7:0] + v[15:8] + v[23:16] + v[31:24];
        return s[CHUNK_CNT_W-1:0];
    endfunction

endpackage

>>> rtl/hamming_nearest_descriptor_match_top.sv
// Top level of the brute-force Hamming nearest-descriptor matcher.
//
// The block keeps a table of up to MaxRefs 256-bit reference descriptors in one
// synchronous RAM and answers queries by scanning the table in index order.
// Each input beat carries a kind in tuser: clear empties the table at once,
// append writes the descriptor at the next free entry (dropped when the table
// is full), and query compares the descriptor against every stored entry. A
// query with has_depth clear, and the unused kind, are swallowed without a
// result. A searched query gives exactly one output beat with the echoed tag,
// the index of the last entry whose distance was strictly below the running
// best (which starts at match_threshold), which is the earliest entry with the
// smallest such distance, that distance, and a matched flag in tuser; with no
// such entry the index is 0 and the distance is the threshold. During a query
// scan the single RAM read port delivers one descriptor per cycle, followed by
// a popcount stage, a sum-and-compare stage and the hand-off to the output
// register. The output register lets the block take the next beat while an
// earlier result is still waiting on m_tready. The threshold is written
// through cfg_we/cfg_wdata; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module hamming_nearest_descriptor_match_top #(
    parameter int MaxRefs = hndm_pkg::DEF_MAX_REFS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Threshold register write.
    input  logic                           cfg_we,
    input  logic [hndm_pkg::DIST_W-1:0]    cfg_wdata,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Low to high: desc_w0, desc_w1, desc_w2, desc_w3, query_tag.
    input  logic [hndm_pkg::S_TDATA_W-1:0] s_tdata,
    // Low to high: kind, has_depth.
    input  logic [hndm_pkg::S_TUSER_W-1:0] s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Low to high: tag_out, best_index, best_distance, zero padding.
    output logic [hndm_pkg::M_TDATA_W-1:0] m_tdata,
    // Low to high: matched.
    output logic [hndm_pkg::M_TUSER_W-1:0] m_tuser
);

    import hndm_pkg::*;

    `include "hamming_nearest_descriptor_match_top_assert.svh"

    localparam int IdxW = (MaxRefs > 1) ? $clog2(MaxRefs) : 1;
    localparam int CntW = $clog2(MaxRefs + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [DIST_W-1:0] thr_reg;
    logic [CntW-1:0]   ref_count_reg;

    // Query context.
    logic [DESC_W-1:0] query_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [CntW-1:0]   rd_idx_reg;

    // Scan pipeline.
    logic                  p1_v_reg;
    logic [IdxW-1:0]       idx_p1_reg;
    logic                  p2_v_reg;
    logic [IdxW-1:0]       idx_p2_reg;
    logic [CHUNK_CNT_W-1:0] pc_reg [NUM_CHUNKS];

    // Running best.
    logic [DIST_W-1:0] best_reg;
    logic [IdxW-1:0]   best_idx_reg;
    logic              hit_reg;

    // Output register.
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic              s_fire;
    kind_t             in_kind;
    logic              in_has_depth;
    logic              start_query;
    logic              ram_we;
    logic              ram_re;
    logic [DESC_W-1:0] ram_rdata;
    logic [DESC_W-1:0] diff;
    logic [DIST_W-1:0] dist_sum;
    logic              scan_empty;
    logic              out_load;

    assign s_tready     = (state_reg == ST_IDLE);
    assign s_fire       = s_tvalid && s_tready;
    assign in_kind      = kind_t'(s_tuser[KIND_W-1:0]);
    assign in_has_depth = s_tuser[KIND_W];
    assign start_query  = s_fire && (in_kind == KIND_QUERY) && in_has_depth;
    assign ram_we       = s_fire && (in_kind == KIND_APPEND) &&
                          (ref_count_reg < CntW'(MaxRefs));
    assign ram_re       = (state_reg == ST_SCAN) && (rd_idx_reg < ref_count_reg);
    assign scan_empty   = !ram_re && !p1_v_reg && !p2_v_reg;
    assign out_load     = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    hndm_ram #(
        .Width (DESC_W),
        .Depth (MaxRefs)
    ) u_ref_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ref_count_reg[IdxW-1:0]),
        .wdata (s_tdata[DESC_W-1:0]),
        .re    (ram_re),
        .raddr (rd_idx_reg[IdxW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start_query) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_empty) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THR_RESET;
            ref_count_reg <= '0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            p1_v_reg  <= ram_re;
            p2_v_reg  <= p1_v_reg;
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            if (s_fire && (in_kind == KIND_CLEAR)) begin
                ref_count_reg <= '0;
            end else if (ram_we) begin
                ref_count_reg <= ref_count_reg + 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // The query descriptor is XORed with each entry as it leaves the RAM and
    // the 256 difference bits are counted in eight 32-bit slices.
    assign diff = ram_rdata ^ query_reg;

    always_ff @(posedge aclk) begin
        idx_p1_reg <= rd_idx_reg[IdxW-1:0];
        idx_p2_reg <= idx_p1_reg;
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            pc_reg[c] <= ones32(diff[c*CHUNK_W +: CHUNK_W]);
        end
    end

    always_comb begin
        dist_sum = '0;
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            dist_sum = dist_sum + DIST_W'(pc_reg[c]);
        end
    end

    // Query context and running best. A strict compare keeps the earliest
    // entry among equal distances.
    always_ff @(posedge aclk) begin
        if (start_query) begin
            query_reg    <= s_tdata[DESC_W-1:0];
            tag_reg      <= s_tdata[DESC_W +: TAG_W];
            rd_idx_reg   <= '0;
            best_reg     <= thr_reg;
            best_idx_reg <= '0;
            hit_reg      <= 1'b0;
        end else begin
            if (ram_re) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (p2_v_reg && (dist_sum < best_reg)) begin
                best_reg     <= dist_sum;
                best_idx_reg <= idx_p2_reg;
                hit_reg      <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'({best_reg, IDX_OUT_W'(best_idx_reg), tag_reg});
            m_tuser_reg <= hit_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `HNDM_ASSERT_NOW(a_count_bound, 1'b1, ref_count_reg <= CntW'(MaxRefs), "table count overflow")
    `HNDM_ASSERT_NOW(a_write_idle, ram_we, state_reg == ST_IDLE, "table written during a scan")
    `HNDM_ASSERT_NOW(a_pipe_in_scan, p2_v_reg, state_reg == ST_SCAN, "compare outside a scan")
    `HNDM_ASSERT_NOW(a_hit_below_thr, (state_reg == ST_DONE) && hit_reg, best_reg < thr_reg, "hit not below threshold")

endmodule

>>> rtl/hndm_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module hndm_ram #(
    parameter int  Width = 64,
    parameter int  Depth = 1024,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [Width-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [Width-1:0] rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
